[hw/rtl/length_prefixed_frame_parser_core_macros.svh]
// Assertion macros shared by the frame parser RTL.
// Used by lpfp_parser and length_prefixed_frame_parser_core; no other dependencies.
`ifndef LENGTH_PREFIXED_FRAME_PARSER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lpfp_pkg.sv]
// Shared types and constants for the length-prefixed frame parser.
// No dependencies; used by every module of the block.
package lpfp_pkg;

    // Frame layout
    localparam logic [15:0] TYPE_BYTES   = 16'd4;
    localparam logic [15:0] BITMAP_BYTES = 16'd16;
    localparam logic [7:0]  MAX_ELEMENTS = 8'd128;
    localparam logic [7:0]  ELEM_SAT     = 8'd255;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_BITMAP  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        RG_TYPE   = 3'd0,
        RG_BITMAP = 3'd1,
        RG_LENGTH = 3'd2,
        RG_KEPT   = 3'd3,
        RG_DROP   = 3'd4
    } t_region;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_GOOD      = 3'd1,
        ST_HDR_SHORT = 3'd2,
        ST_LEN_SHORT = 3'd3,
        ST_PAY_SHORT = 3'd4
    } t_status;

    // One input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_item;

    // One result word
    typedef struct packed {
        t_region     region;
        logic [7:0]  element_number;
        logic [15:0] byte_offset;
        logic [7:0]  value_out;
        logic [15:0] element_length;
        logic        element_complete;
        logic        frame_complete;
        t_status     frame_status;
    } t_result;

endpackage

[hw/rtl/length_prefixed_frame_parser_core.sv]
// Top level of the length-prefixed frame parser.
// Depends on lpfp_pkg, lpfp_in_stage, lpfp_parser, lpfp_out_stage and the macros header.
`include "length_prefixed_frame_parser_core_macros.svh"

// Parses a frame (4-byte type code, 16-byte bitmap, then elements each made of a
// 2-byte big-endian length and its payload) one byte per word and returns one
// result word per input word, in order. Throughput is one word per clock when
// the output is not stalled. An accepted word is held in the input register,
// then passes through the parse logic into the result register, which drives
// o_valid. The parse state updates in the same cycle as the word moves from
// the input register to the result register, so consecutive bytes of a frame
// follow back to back.
module length_prefixed_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_region,
    output logic [7:0]  o_element_number,
    output logic [15:0] o_byte_offset,
    output logic [7:0]  o_value_out,
    output logic [15:0] o_element_length,
    output logic        o_element_complete,
    output logic        o_frame_complete,
    output logic [2:0]  o_frame_status
);

    lpfp_pkg::t_item   in_item;
    lpfp_pkg::t_item   stage_item;
    lpfp_pkg::t_result parse_res;
    lpfp_pkg::t_result out_res;
    logic              stage_valid;
    logic              out_valid;
    logic              out_free;
    logic              advance;
    logic              in_load;

    // Pipeline control: the result register frees up when empty or taken
    assign out_free = !out_valid || !i_stall;
    assign advance  = stage_valid && out_free;
    assign o_stall  = stage_valid && !out_free;
    assign in_load  = i_valid && !o_stall;

    assign in_item.data_byte  = i_data_byte;
    assign in_item.final_byte = i_final_byte;

    lpfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_load),
        .i_item  (in_item),
        .i_drain (advance),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    lpfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (stage_item),
        .o_result (parse_res)
    );

    lpfp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (parse_res),
        .i_stall  (i_stall),
        .o_valid  (out_valid),
        .o_result (out_res)
    );

    // Result fields
    assign o_valid            = out_valid;
    assign o_region           = out_res.region;
    assign o_element_number   = out_res.element_number;
    assign o_byte_offset      = out_res.byte_offset;
    assign o_value_out        = out_res.value_out;
    assign o_element_length   = out_res.element_length;
    assign o_element_complete = out_res.element_complete;
    assign o_frame_complete   = out_res.frame_complete;
    assign o_frame_status     = out_res.frame_status;

    `LPFP_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, stage_valid && out_valid && i_stall, "input stalled with room downstream")
    `LPFP_ASSERT_NEXT(a_accept_reaches_stage, i_clk, i_rst_n, i_valid && !o_stall, stage_valid, "accepted word not held in input register")
    `LPFP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_res), "stalled result word changed")

endmodule

[hw/rtl/lpfp_in_stage.sv]
// Input register of the frame parser: holds one accepted word until parsed.
// Depends on lpfp_pkg.
module lpfp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  lpfp_pkg::t_item i_item,
    input  logic           i_drain,
    output logic           o_valid,
    output lpfp_pkg::t_item o_item
);

    logic            r_valid;
    lpfp_pkg::t_item r_item;

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_drain) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hw/rtl/lpfp_parser.sv]
// Frame parse state and the combinational next-state / result logic.
// Depends on lpfp_pkg and length_prefixed_frame_parser_core_macros.svh.
`include "length_prefixed_frame_parser_core_macros.svh"

module lpfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  lpfp_pkg::t_item   i_item,
    output lpfp_pkg::t_result o_result
);

    lpfp_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_pos, n_pos;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_cnt, n_cnt;
    logic             r_zero, n_zero;

    logic [15:0]       pos_inc;
    logic [7:0]        cnt_inc;
    logic [15:0]       len_full;
    logic              zero_now;
    logic              kept;
    logic              done_ok;
    lpfp_pkg::t_status short_code;
    lpfp_pkg::t_result res;

    assign pos_inc  = r_pos + 16'd1;
    assign cnt_inc  = (r_cnt != lpfp_pkg::ELEM_SAT) ? (r_cnt + 8'd1) : r_cnt;
    assign len_full = r_len | {8'h00, i_item.data_byte};
    assign zero_now = r_zero || (i_item.data_byte == 8'h00);
    assign kept     = (r_cnt <= lpfp_pkg::MAX_ELEMENTS);

    // Next state and result for the word at the input register
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_zero     = r_zero;
        done_ok    = 1'b0;
        short_code = lpfp_pkg::ST_HDR_SHORT;

        res                  = '0;
        res.region           = lpfp_pkg::RG_TYPE;
        res.frame_complete   = i_item.final_byte;
        res.frame_status     = lpfp_pkg::ST_BUSY;

        case (r_phase)
            lpfp_pkg::PH_BITMAP: begin
                res.region      = lpfp_pkg::RG_BITMAP;
                res.byte_offset = r_pos;
                res.value_out   = i_item.data_byte;
                n_pos           = pos_inc;
                if (pos_inc >= lpfp_pkg::BITMAP_BYTES) begin
                    n_phase = lpfp_pkg::PH_LEN_HI;
                    n_pos   = 16'd0;
                    done_ok = 1'b1;
                end
            end
            lpfp_pkg::PH_LEN_HI: begin
                n_cnt              = cnt_inc;
                res.region         = lpfp_pkg::RG_LENGTH;
                res.element_number = cnt_inc;
                res.value_out      = i_item.data_byte;
                n_len              = {i_item.data_byte, 8'h00};
                n_phase            = lpfp_pkg::PH_LEN_LO;
                short_code         = lpfp_pkg::ST_LEN_SHORT;
            end
            lpfp_pkg::PH_LEN_LO: begin
                res.region         = lpfp_pkg::RG_LENGTH;
                res.element_number = r_cnt;
                res.byte_offset    = 16'd1;
                res.value_out      = i_item.data_byte;
                res.element_length = len_full;
                n_len              = len_full;
                if (len_full == 16'd0) begin
                    // empty element ends on its prefix
                    res.element_complete = 1'b1;
                    n_phase              = lpfp_pkg::PH_LEN_HI;
                    done_ok              = 1'b1;
                end else begin
                    n_phase    = lpfp_pkg::PH_PAYLOAD;
                    n_pos      = 16'd0;
                    n_zero     = 1'b0;
                    short_code = lpfp_pkg::ST_PAY_SHORT;
                end
            end
            lpfp_pkg::PH_PAYLOAD: begin
                res.region         = kept ? lpfp_pkg::RG_KEPT : lpfp_pkg::RG_DROP;
                res.element_number = r_cnt;
                res.byte_offset    = r_pos;
                res.element_length = r_len;
                if (kept) begin
                    n_zero        = zero_now;
                    res.value_out = zero_now ? 8'h00 : i_item.data_byte;
                end
                n_pos = pos_inc;
                if (pos_inc == r_len) begin
                    res.element_complete = 1'b1;
                    n_phase              = lpfp_pkg::PH_LEN_HI;
                    n_pos                = 16'd0;
                    done_ok              = 1'b1;
                end else begin
                    short_code = lpfp_pkg::ST_PAY_SHORT;
                end
            end
            default: begin
                // type code; unused phase codes land here too
                n_phase         = lpfp_pkg::PH_TYPE;
                res.region      = lpfp_pkg::RG_TYPE;
                res.byte_offset = r_pos;
                n_zero          = zero_now;
                res.value_out   = zero_now ? 8'h00 : i_item.data_byte;
                n_pos           = pos_inc;
                if (pos_inc >= lpfp_pkg::TYPE_BYTES) begin
                    n_phase = lpfp_pkg::PH_BITMAP;
                    n_pos   = 16'd0;
                end
            end
        endcase

        // Final word: report and start the next frame from scratch
        if (i_item.final_byte) begin
            res.frame_status = done_ok ? lpfp_pkg::ST_GOOD : short_code;
            n_phase          = lpfp_pkg::PH_TYPE;
            n_pos            = 16'd0;
            n_len            = 16'd0;
            n_cnt            = 8'd0;
            n_zero           = 1'b0;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lpfp_pkg::PH_TYPE;
            r_pos   <= 16'd0;
            r_len   <= 16'd0;
            r_cnt   <= 8'd0;
            r_zero  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_zero  <= n_zero;
        end
    end

    assign o_result = res;

    `LPFP_ASSERT_NEXT(a_final_restarts, i_clk, i_rst_n, i_fire && i_item.final_byte, (r_phase == lpfp_pkg::PH_TYPE) && (r_cnt == 8'd0) && (r_pos == 16'd0), "frame did not restart after final byte")
    `LPFP_ASSERT_NEXT(a_prefix_counts, i_clk, i_rst_n, i_fire && !i_item.final_byte && (r_phase == lpfp_pkg::PH_LEN_HI), r_cnt != 8'd0, "element count zero after a length prefix")
    `LPFP_ASSERT_NOW(a_complete_region, i_clk, i_rst_n, res.element_complete, (res.region == lpfp_pkg::RG_LENGTH) || (res.region == lpfp_pkg::RG_KEPT) || (res.region == lpfp_pkg::RG_DROP), "element completes outside an element")
    `LPFP_ASSERT_NOW(a_status_on_final, i_clk, i_rst_n, i_fire, (res.frame_status != lpfp_pkg::ST_BUSY) == i_item.final_byte, "status does not match final flag")

endmodule

[hw/rtl/lpfp_out_stage.sv]
// Result register of the frame parser: holds one result until taken.
// Depends on lpfp_pkg.
module lpfp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lpfp_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output lpfp_pkg::t_result o_result
);

    logic              r_valid;
    lpfp_pkg::t_result r_result;

    // Occupancy: filled on load, emptied when taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
